/* hw/rtl/pngcs_pkg.sv */
// Package for the PNG chunk stream splitter: phase codes, kind codes,
// chunk type tags, the descriptor struct and the type classifier.
// No dependencies.
package pngcs_pkg;

	localparam int DEF_MAX_CHUNKS = 16;
	localparam int CNT_W          = 5;
	localparam int NUM_W          = 4;
	localparam int WORD_W         = 32;
	localparam int KIND_W         = 3;

	typedef enum logic [1:0] {
		PH_LEN  = 2'd0,
		PH_TYPE = 2'd1,
		PH_DATA = 2'd2,
		PH_CRC  = 2'd3
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_UNKNOWN = 3'd0,
		KIND_IHDR    = 3'd1,
		KIND_PLTE    = 3'd2,
		KIND_IDAT    = 3'd3,
		KIND_IEND    = 3'd4
	} kind_t;

	localparam logic [WORD_W-1:0] TAG_IHDR = 32'h4948_4452;
	localparam logic [WORD_W-1:0] TAG_PLTE = 32'h504C_5445;
	localparam logic [WORD_W-1:0] TAG_IDAT = 32'h4944_4154;
	localparam logic [WORD_W-1:0] TAG_IEND = 32'h4945_4E44;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [NUM_W-1:0]  chunk_number;
		logic [WORD_W-1:0] chunk_length;
		kind_t             chunk_kind;
		logic [WORD_W-1:0] data_offset;
		logic              has_data;
		logic [WORD_W-1:0] stored_crc;
		logic              truncated;
		logic              final_chunk;
	} desc_t;

	function automatic kind_t classify(input logic [WORD_W-1:0] tag);
		kind_t k;
		unique case (tag)
			TAG_IHDR: k = KIND_IHDR;
			TAG_PLTE: k = KIND_PLTE;
			TAG_IDAT: k = KIND_IDAT;
			TAG_IEND: k = KIND_IEND;
			default:  k = KIND_UNKNOWN;
		endcase
		return k;
	endfunction

endpackage

/* hw/rtl/pngcs_parser.sv */
// Per-byte chunk parser: field phase state machine, shift registers and
// counters; builds the descriptor for the byte being stepped. Uses pngcs_pkg.
module pngcs_parser import pngcs_pkg::*; #(
	parameter int MAX_CHUNKS = DEF_MAX_CHUNKS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_item_t item,
	output logic     desc_valid,
	output desc_t    desc
);

	phase_t            phase_q, phase_n;
	logic [1:0]        bif_q, bif_n;
	logic [WORD_W-1:0] len_q, len_n;
	logic [WORD_W-1:0] type_q, type_n;
	logic [WORD_W-1:0] rem_q, rem_n;
	logic [WORD_W-1:0] pos_q, pos_n;
	logic [WORD_W-1:0] start_q, start_n;
	logic [WORD_W-1:0] crc_q, crc_n;
	logic [CNT_W-1:0]  cnt_q, cnt_n, cnt_inc;
	logic              full_q, full_n, full_inc;
	logic              complete, type_done, eos;
	logic [7:0]        b;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHUNKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN;
			bif_q   <= '0;
			len_q   <= '0;
			type_q  <= '0;
			rem_q   <= '0;
			pos_q   <= '0;
			start_q <= '0;
			crc_q   <= '0;
			cnt_q   <= '0;
			full_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			bif_q   <= bif_n;
			len_q   <= len_n;
			type_q  <= type_n;
			rem_q   <= rem_n;
			pos_q   <= pos_n;
			start_q <= start_n;
			crc_q   <= crc_n;
			cnt_q   <= cnt_n;
			full_q  <= full_n;
		end
	end

	always_comb begin
		b        = item.byte_value;
		eos      = item.end_of_stream;
		phase_n  = phase_q;
		bif_n    = bif_q;
		len_n    = len_q;
		type_n   = type_q;
		rem_n    = rem_q;
		pos_n    = pos_q;
		start_n  = start_q;
		crc_n    = crc_q;
		cnt_n    = cnt_q;
		full_n   = full_q;
		complete = 1'b0;
		cnt_inc  = cnt_q + 1'b1;
		full_inc = (cnt_inc >= MAX_CNT);
		desc     = '0;
		desc_valid = 1'b0;
		type_done  = 1'b0;

		if (!full_q) begin
			unique case (phase_q)
				PH_LEN: begin
					len_n = {len_q[WORD_W-9:0], b};
					bif_n = bif_q + 1'b1;
					if (bif_q == 2'd3) phase_n = PH_TYPE;
				end
				PH_TYPE: begin
					type_n = {type_q[WORD_W-9:0], b};
					bif_n  = bif_q + 1'b1;
					if (bif_q == 2'd3) begin
						rem_n   = len_q;
						start_n = pos_q + 1'b1;
						phase_n = (len_q == '0) ? PH_CRC : PH_DATA;
					end
				end
				PH_DATA: begin
					rem_n = rem_q - 1'b1;
					if (rem_n == '0) phase_n = PH_CRC;
				end
				PH_CRC: begin
					crc_n = {crc_q[WORD_W-9:0], b};
					bif_n = bif_q + 1'b1;
					if (bif_q == 2'd3) complete = 1'b1;
				end
				default: phase_n = PH_LEN;
			endcase
			pos_n = pos_q + 1'b1;

			// type is settled once the phase has moved past it
			type_done = complete || phase_n == PH_DATA || phase_n == PH_CRC;
			desc_valid = complete || eos;
			desc.chunk_number = cnt_q[NUM_W-1:0];
			desc.chunk_length = len_n;
			desc.chunk_kind   = type_done ? classify(type_n) : KIND_UNKNOWN;
			desc.data_offset  = type_done ? start_n : '0;
			desc.has_data     = type_done && (len_n != '0);
			desc.stored_crc   = crc_n;
			desc.truncated    = !complete;
			desc.final_chunk  = full_inc || eos;

			if (desc_valid) begin
				phase_n = PH_LEN;
				bif_n   = '0;
				len_n   = '0;
				type_n  = '0;
				rem_n   = '0;
				start_n = '0;
				crc_n   = '0;
				cnt_n   = cnt_inc;
				full_n  = full_inc;
			end
		end

		if (eos) begin
			phase_n = PH_LEN;
			bif_n   = '0;
			len_n   = '0;
			type_n  = '0;
			rem_n   = '0;
			start_n = '0;
			crc_n   = '0;
			pos_n   = '0;
			cnt_n   = '0;
			full_n  = 1'b0;
		end
	end

endmodule

/* hw/rtl/png_chunk_stream_splitter_core.sv */
// Top level of the PNG chunk stream splitter: input word register,
// parser and descriptor output register. Uses pngcs_pkg and pngcs_parser.
//
// Takes one byte of a PNG chunk stream (signature removed) per word and
// sends one descriptor word per chunk after the last CRC byte, or a
// truncated descriptor when tlast arrives inside a chunk. Throughput is one
// byte per clock unless the output stalls, fixed by the parser's per-byte
// state update; each byte is held in the input word register, and its
// descriptor in the descriptor output register. Output backpressure stalls
// the input only while the descriptor register is full and not taken. After
// MAX_CHUNKS descriptors, bytes are swallowed until tlast. No clearing pass after reset.
module png_chunk_stream_splitter_core import pngcs_pkg::*; #(
	parameter int MAX_CHUNKS = DEF_MAX_CHUNKS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // byte_value
	input  logic         s_axis_tlast,  // end_of_stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// chunk_number[3:0], chunk_length[35:4], chunk_kind[38:36],
	// data_offset[70:39], has_data[71], stored_crc[103:72]
	output logic [103:0] m_axis_tdata,
	output logic [0:0]   m_axis_tuser,  // truncated
	output logic         m_axis_tlast   // final_chunk
);

	logic     valid_s1;
	in_item_t item_s1;
	logic     advance;
	logic     desc_valid;
	desc_t    desc;
	logic     m_valid_q;
	desc_t    desc_q;

	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.byte_value    <= s_axis_tdata;
			item_s1.end_of_stream <= s_axis_tlast;
		end
	end

	pngcs_parser #(
		.MAX_CHUNKS(MAX_CHUNKS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.desc_valid(desc_valid),
		.desc      (desc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else begin
			if (m_axis_tready) m_valid_q <= 1'b0;
			if (advance && desc_valid) m_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && desc_valid) desc_q <= desc;
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {desc_q.stored_crc, desc_q.has_data, desc_q.data_offset,
		desc_q.chunk_kind, desc_q.chunk_length, desc_q.chunk_number};
	assign m_axis_tuser  = desc_q.truncated;
	assign m_axis_tlast  = desc_q.final_chunk;

endmodule

/* hw/rtl/pngcs_checker.sv */
// Port-level checks for png_chunk_stream_splitter_core, bound to the top.
// Uses pngcs_pkg for the kind codes.
module pngcs_checker import pngcs_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [103:0] m_axis_tdata,
	input logic [0:0]   m_axis_tuser,
	input logic         m_axis_tlast
);

	// a held descriptor word does not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("descriptor changed while stalled");

	// input stalls only behind a full, untaken output register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// a truncated chunk always ends the list
	a_trunc_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
		else $error("truncated descriptor not marked final");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[38:36] <= KIND_IEND)
		else $error("chunk kind out of range");

	// has_data only with a nonzero length
	a_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[71] |-> m_axis_tdata[35:4] != 32'd0)
		else $error("has_data set on empty chunk");

endmodule

bind png_chunk_stream_splitter_core pngcs_checker u_pngcs_checker (.*);

/* verif/png_chunk_stream_splitter_core_tb.sv */
// Testbench for png_chunk_stream_splitter_core: feeds PNG chunk streams one byte
// per word and checks every descriptor against a built-in scoreboard.
// Depends on pngcs_pkg and the RTL under hw/rtl only.
`timescale 1ns / 100ps

module png_chunk_stream_splitter_core_tb;
	import pngcs_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 8;
	localparam int RANDOM_BYTES = 1300;

	// Tracks the chunk parse and queues the descriptors it predicts.
	class chunk_scoreboard;
		desc_t       want_q[$];
		int          errors;
		phase_t      phase;
		logic [1:0]  nib;
		logic [31:0] len_sr;
		logic [31:0] type_sr;
		logic [31:0] skip_left;
		logic [31:0] position;
		logic [31:0] start;
		logic [31:0] crc_sr;
		logic [4:0]  found;
		bit          full;

		function new();
			errors = 0;
			restart();
		endfunction

		function void drop_chunk();
			phase = PH_LEN;
			nib = 2'd0;
			len_sr = '0;
			type_sr = '0;
			skip_left = '0;
			start = '0;
			crc_sr = '0;
		endfunction

		function void restart();
			drop_chunk();
			position = '0;
			found = '0;
			full = 1'b0;
		endfunction

		function kind_t kind_of(logic [31:0] tag);
			case (tag)
				TAG_IHDR: return KIND_IHDR;
				TAG_PLTE: return KIND_PLTE;
				TAG_IDAT: return KIND_IDAT;
				TAG_IEND: return KIND_IEND;
				default:  return KIND_UNKNOWN;
			endcase
		endfunction

		function void note_byte(logic [7:0] b, logic eos);
			desc_t       d;
			logic [31:0] pos;
			bit          complete;
			bit          type_done;
			pos = position;
			complete = 1'b0;
			if (full) begin
				// list closed: bytes are swallowed, only tlast matters
				if (eos)
					restart();
				return;
			end
			case (phase)
				PH_LEN: begin
					len_sr = {len_sr[23:0], b};
					nib = nib + 2'd1;
					if (nib == 2'd0)
						phase = PH_TYPE;
				end
				PH_TYPE: begin
					type_sr = {type_sr[23:0], b};
					nib = nib + 2'd1;
					if (nib == 2'd0) begin
						skip_left = len_sr;
						start = pos + 32'd1;
						phase = (len_sr == 32'd0) ? PH_CRC : PH_DATA;
					end
				end
				PH_DATA: begin
					skip_left = skip_left - 32'd1;
					if (skip_left == 32'd0)
						phase = PH_CRC;
				end
				default: begin
					crc_sr = {crc_sr[23:0], b};
					nib = nib + 2'd1;
					if (nib == 2'd0)
						complete = 1'b1;
				end
			endcase
			position = pos + 32'd1;
			if (complete || eos) begin
				type_done = complete || phase == PH_DATA || phase == PH_CRC;
				d.chunk_number = found[3:0];
				d.chunk_length = len_sr;
				d.chunk_kind = type_done ? kind_of(type_sr) : KIND_UNKNOWN;
				d.data_offset = type_done ? start : '0;
				d.has_data = type_done && len_sr != 32'd0;
				d.stored_crc = crc_sr;
				d.truncated = !complete;
				found = found + 5'd1;
				if (found >= 5'(DEF_MAX_CHUNKS))
					full = 1'b1;
				d.final_chunk = full || eos;
				want_q.push_back(d);
				drop_chunk();
			end
			if (eos)
				restart();
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check(desc_t got);
			desc_t want;
			if (want_q.size() == 0) begin
				$display("%0t: unexpected descriptor, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = want_q.pop_front();
			check_field("chunk_number", 32'(want.chunk_number), 32'(got.chunk_number));
			check_field("chunk_length", want.chunk_length, got.chunk_length);
			check_field("chunk_kind", 32'(want.chunk_kind), 32'(got.chunk_kind));
			check_field("data_offset", want.data_offset, got.data_offset);
			check_field("has_data", 32'(want.has_data), 32'(got.has_data));
			check_field("stored_crc", want.stored_crc, got.stored_crc);
			check_field("truncated", 32'(want.truncated), 32'(got.truncated));
			check_field("final_chunk", 32'(want.final_chunk), 32'(got.final_chunk));
		endfunction
	endclass

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = '0;
	logic         s_axis_tlast = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;
	logic [0:0]   m_axis_tuser;
	logic         m_axis_tlast;

	chunk_scoreboard sb;
	desc_t           seen;
	logic [7:0]      stream_q[$];
	bit              src_burst = 1'b0;
	bit              snk_burst = 1'b0;
	int              items_sent = 0;
	int              bytes_in = 0;
	int              words_out = 0;
	int              trunc_cnt = 0;
	int              last_cnt = 0;
	int              idle = 0;

	png_chunk_stream_splitter_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Entered at a falling edge; returns at the falling edge after the handshake.
	task automatic send_word(input logic [7:0] b, input logic eos);
		int gap;
		gap = src_burst ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= eos;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		items_sent++;
	endtask

	function automatic void push_word(logic [31:0] w);
		stream_q.push_back(w[31:24]);
		stream_q.push_back(w[23:16]);
		stream_q.push_back(w[15:8]);
		stream_q.push_back(w[7:0]);
	endfunction

	// Known tags, near misses with one bit flipped, and random types.
	function automatic logic [31:0] pick_tag();
		logic [31:0] known[4];
		int          sel;
		known[0] = TAG_IHDR;
		known[1] = TAG_PLTE;
		known[2] = TAG_IDAT;
		known[3] = TAG_IEND;
		sel = $urandom_range(0, 5);
		if (sel < 4)
			return known[sel];
		if (sel == 4)
			return $urandom;
		return known[$urandom_range(0, 3)] ^ (32'd1 << $urandom_range(0, 31));
	endfunction

	task automatic trim_to(input int cut);
		while (stream_q.size() > cut)
			void'(stream_q.pop_back());
	endtask

	task automatic play_stream();
		int n;
		n = stream_q.size();
		for (int i = 0; i < n; i++)
			send_word(stream_q[i], i == n - 1);
		stream_q.delete();
	endtask

	task automatic random_stream();
		int          mode;
		int          nchunks;
		int          len;
		mode = $urandom_range(0, 9);
		src_burst = ($urandom_range(0, 3) == 0);
		if (mode <= 5) begin
			// well-formed chunks, sometimes enough to fill the list, sometimes cut short
			nchunks = $urandom_range(1, 20);
			for (int i = 0; i < nchunks; i++) begin
				len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				if ($urandom_range(0, 15) == 0)
					len = $urandom_range(9, 40);
				push_word(len);
				push_word(pick_tag());
				repeat (len) stream_q.push_back(8'($urandom));
				push_word($urandom);
			end
			if ($urandom_range(0, 1) == 0)
				trim_to($urandom_range(1, stream_q.size()));
		end else if (mode <= 7) begin
			// header with a random full-width length, cut short
			push_word($urandom);
			push_word(pick_tag());
			repeat ($urandom_range(0, 6)) stream_q.push_back(8'($urandom));
			trim_to($urandom_range(1, stream_q.size()));
		end else begin
			repeat ($urandom_range(1, 40)) stream_q.push_back(8'($urandom));
		end
		play_stream();
	endtask

	// Sink: a random stall before each word, with stretches of none.
	initial begin
		int gap;
		forever begin
			gap = snk_burst ? 0 : $urandom_range(0, 13);
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
			if ($urandom_range(0, 39) == 0)
				snk_burst = !snk_burst;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen.chunk_number = m_axis_tdata[3:0];
				seen.chunk_length = m_axis_tdata[35:4];
				seen.chunk_kind = kind_t'(m_axis_tdata[38:36]);
				seen.data_offset = m_axis_tdata[70:39];
				seen.has_data = m_axis_tdata[71];
				seen.stored_crc = m_axis_tdata[103:72];
				seen.truncated = m_axis_tuser[0];
				seen.final_chunk = m_axis_tlast;
				sb.check(seen);
				words_out++;
				trunc_cnt += int'(seen.truncated);
				last_cnt += int'(seen.final_chunk);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				sb.note_byte(s_axis_tdata, s_axis_tlast);
				bytes_in++;
			end
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
				idle = 0;
			end else begin
				idle++;
				if (idle >= IDLE_LIMIT) begin
					$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
					$display("[png_chunk_stream_splitter_core] ERROR");
					$finish;
				end
			end
		end
	end

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// lone byte ending the stream: truncated inside the length field
		send_word(8'hFF, 1'b1);
		// empty IEND chunk ending exactly on its last CRC byte
		push_word(32'd0);
		push_word(TAG_IEND);
		push_word(32'hAE42_6082);
		play_stream();
		// maximal length, stream ends inside the data
		push_word(32'hFFFF_FFFF);
		push_word(TAG_IDAT);
		stream_q.push_back(8'h00);
		stream_q.push_back(8'hFF);
		play_stream();

		while (items_sent < RANDOM_BYTES + 23)
			random_stream();
		s_axis_tvalid <= 1'b0;

		while (sb.want_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d bytes in, %0d descriptors checked", bytes_in, words_out);
		$display("%0d truncated, %0d marked as the last of a list", trunc_cnt, last_cnt);
		if (sb.errors == 0 && sb.want_q.size() == 0) begin
			$display("[png_chunk_stream_splitter_core] OK");
		end else begin
			$display("[png_chunk_stream_splitter_core] ERROR");
		end
		$finish;
	end

endmodule

/* png_chunk_stream_splitter_core.f */
hw/rtl/pngcs_pkg.sv
hw/rtl/pngcs_parser.sv
hw/rtl/png_chunk_stream_splitter_core.sv
hw/rtl/pngcs_checker.sv
verif/png_chunk_stream_splitter_core_tb.sv
